FILE: sv/bpfa_pkg.sv
// Shared types, codes and word helper functions of the bitmap page frame allocator.
package bpfa_pkg;

	typedef logic [17:0] pos_t;
	typedef logic [16:0] cnt_t;

	localparam cnt_t COUNT_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		FN_ALLOC_ONE = 3'd0,
		FN_ALLOC_RUN = 3'd1,
		FN_FREE_RUN  = 3'd2,
		FN_RESERVE   = 3'd3,
		FN_QUERY     = 3'd4,
		FN_BOOT_REL  = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		STS_OK           = 3'd0,
		STS_NO_SPACE     = 3'd1,
		STS_INVALID      = 3'd2,
		STS_DOUBLE_FREE  = 3'd3,
		STS_ALREADY_USED = 3'd4,
		STS_ZERO_COUNT   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_FIN,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		MODE_ONE,
		MODE_RUN,
		MODE_SET,
		MODE_CLR,
		MODE_SINGLE
	} mode_t;

	localparam logic REG_REGION_START = 1'b0;
	localparam logic REG_REGION_END   = 1'b1;

	typedef struct packed {
		logic [16:0] lo;
		logic [16:0] hi;
	} cfg_t;

	typedef struct packed {
		logic       found;
		logic [5:0] idx;
	} ff_t;

	function automatic logic [63:0] range_mask(input logic [6:0] lo, input logic [6:0] hi);
		logic [63:0] m;
		for (int i = 0; i < 64; i++) begin
			m[i] = (7'(i) >= lo) && (7'(i) < hi);
		end
		return m;
	endfunction

	function automatic ff_t find_first(input logic [63:0] v);
		ff_t r;
		r.found = 1'b0;
		r.idx   = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) begin
				r.found = 1'b1;
				r.idx   = 6'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] popcount(input logic [63:0] v);
		logic [3:0] b [8];
		logic [6:0] r;
		for (int j = 0; j < 8; j++) begin
			b[j] = 4'(v[j*8]) + 4'(v[j*8+1]) + 4'(v[j*8+2]) + 4'(v[j*8+3])
				+ 4'(v[j*8+4]) + 4'(v[j*8+5]) + 4'(v[j*8+6]) + 4'(v[j*8+7]);
		end
		r = 7'(b[0]) + 7'(b[1]) + 7'(b[2]) + 7'(b[3])
			+ 7'(b[4]) + 7'(b[5]) + 7'(b[6]) + 7'(b[7]);
		return r;
	endfunction

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [17:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[17] ? COUNT_MAX : s[16:0];
	endfunction

	function automatic cnt_t sat_sub(input cnt_t a, input cnt_t b);
		return (a > b) ? a - b : 17'd0;
	endfunction

endpackage

FILE: sv/bpfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bpfa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/bpfa_ctrl.sv
// Operation sequencer: scans and updates the used-page bitmap word by word.
module bpfa_ctrl import bpfa_pkg::*; #(
	parameter int unsigned PAGES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] page_number,
	input  logic [16:0] run_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] result_page,
	output logic        page_is_free,
	output logic [16:0] pages_changed,
	output logic [16:0] free_count,
	output logic [16:0] used_count,
	output logic [16:0] total_count
);

	localparam int unsigned EFF   = (PAGES < 65536) ? PAGES : 65536;
	localparam int unsigned WORDS = (EFF + 63) / 64;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam pos_t EFF_POS = pos_t'(EFF);

	state_t state_q, state_d;
	mode_t mode_q, mode_d;
	logic [2:0] func_q, func_d;
	pos_t pos_q, pos_d, lim_q, lim_d, from_q, from_d;
	pos_t run_start_q, run_start_d, streak_q, streak_d, count_q, count_d;
	logic phase_q, phase_d, dbl_q, dbl_d, over_q, over_d;
	status_t status_q, status_d;
	logic [15:0] result_q, result_d, cursor_q, cursor_d;
	logic is_free_q, is_free_d;
	cnt_t changed_q, changed_d, free_q, free_d, used_q, used_d, total_q, total_d;
	logic [AW-1:0] clr_q, clr_d;
	logic go_read;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [63:0] mem_wdata, rdata;

	pos_t lo, hi, pg, pg_end, len;
	pos_t wbase, wend, lim, free_pg, used_pg, run_f, streak_new, from_sel;
	logic [63:0] wmask, free_bits, used_bits;
	ff_t ffree, fused;
	logic at_lim, run_ok, run_fail, bitv;
	logic [6:0] pc_set, pc_clr;

	bpfa_ram #(.WIDTH(64), .DEPTH(WORDS)) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	always_comb begin
		lo         = {1'b0, cfg.lo};
		hi         = {1'b0, cfg.hi};
		pg         = {2'b0, page_number};
		len        = {1'b0, run_length};
		pg_end     = pg + len;
		from_sel   = ({2'b0, cursor_q} >= lo && {2'b0, cursor_q} < hi) ? {2'b0, cursor_q} : lo;
		wbase      = {pos_q[17:6], 6'd0};
		wend       = wbase + 18'd64;
		lim        = (wend < lim_q) ? wend : lim_q;
		wmask      = range_mask({1'b0, pos_q[5:0]}, 7'(lim - wbase));
		free_bits  = ~rdata & wmask;
		used_bits  = rdata & wmask;
		ffree      = find_first(free_bits);
		fused      = find_first(used_bits);
		free_pg    = wbase + {12'd0, ffree.idx};
		used_pg    = wbase + {12'd0, fused.idx};
		at_lim     = (lim == lim_q);
		run_f      = fused.found ? used_pg : lim;
		streak_new = streak_q + (run_f - pos_q);
		run_ok     = (streak_new >= count_q);
		run_fail   = (used_pg + 18'd1 + count_q) > hi;
		pc_set     = popcount(free_bits);
		pc_clr     = popcount(used_bits);
		bitv       = rdata[pos_q[5:0]];
	end

	always_comb begin
		mode_d      = mode_q;
		func_d      = func_q;
		pos_d       = pos_q;
		lim_d       = lim_q;
		from_d      = from_q;
		run_start_d = run_start_q;
		streak_d    = streak_q;
		count_d     = count_q;
		phase_d     = phase_q;
		dbl_d       = dbl_q;
		over_d      = over_q;
		status_d    = status_q;
		result_d    = result_q;
		cursor_d    = cursor_q;
		is_free_d   = is_free_q;
		changed_d   = changed_q;
		free_d      = free_q;
		used_d      = used_q;
		total_d     = total_q;
		clr_d       = clr_q;
		go_read     = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = pos_q[AW+5:6];
		mem_raddr   = pos_q[AW+5:6];
		mem_wdata   = rdata;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '1;
				clr_d     = clr_q + 1'b1;
			end
			S_IDLE: begin
				if (in_valid) begin
					func_d    = func;
					status_d  = STS_OK;
					result_d  = 16'd0;
					is_free_d = 1'b0;
					changed_d = 17'd0;
					dbl_d     = 1'b0;
					over_d    = 1'b0;
					phase_d   = 1'b0;
					unique case (func)
						FN_ALLOC_ONE, FN_ALLOC_RUN: begin
							if (func == FN_ALLOC_RUN && len == 18'd0) begin
								status_d = STS_ZERO_COUNT;
							end else if (func == FN_ALLOC_RUN && len != 18'd1) begin
								count_d = len;
								if (lo + len > hi) begin
									status_d = STS_NO_SPACE;
								end else begin
									pos_d       = lo;
									run_start_d = lo;
									streak_d    = 18'd0;
									lim_d       = hi;
									mode_d      = MODE_RUN;
									go_read     = 1'b1;
								end
							end else if (hi <= lo) begin
								status_d = STS_NO_SPACE;
							end else begin
								pos_d   = from_sel;
								from_d  = from_sel;
								lim_d   = hi;
								mode_d  = MODE_ONE;
								go_read = 1'b1;
							end
						end
						FN_FREE_RUN: begin
							if (len == 18'd0) begin
								status_d = STS_ZERO_COUNT;
							end else begin
								status_d = (pg < lo || pg >= hi) ? STS_INVALID : STS_OK;
								over_d   = (pg_end > hi);
								pos_d    = (pg < lo) ? lo : pg;
								lim_d    = (pg_end < hi) ? pg_end : hi;
								mode_d   = MODE_CLR;
								go_read  = (((pg < lo) ? lo : pg) < ((pg_end < hi) ? pg_end : hi));
							end
						end
						FN_RESERVE, FN_QUERY: begin
							if (pg >= lo && pg < hi) begin
								pos_d   = pg;
								mode_d  = MODE_SINGLE;
								go_read = 1'b1;
							end else if (func == FN_RESERVE) begin
								status_d = STS_INVALID;
							end
						end
						FN_BOOT_REL: begin
							if (len == 18'd0) begin
								status_d = STS_ZERO_COUNT;
							end else begin
								pos_d   = pg;
								lim_d   = (pg_end < EFF_POS) ? pg_end : EFF_POS;
								mode_d  = MODE_CLR;
								go_read = (pg < ((pg_end < EFF_POS) ? pg_end : EFF_POS));
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
			end
			S_EVAL: begin
				unique case (mode_q)
					MODE_ONE: begin
						if (ffree.found) begin
							mem_we    = 1'b1;
							mem_wdata = rdata | (64'd1 << ffree.idx);
							result_d  = free_pg[15:0];
							changed_d = 17'd1;
							cursor_d  = (free_pg + 18'd1 < hi) ? 16'(free_pg + 18'd1) : lo[15:0];
						end else if (!at_lim) begin
							pos_d   = lim;
							go_read = 1'b1;
						end else if (!phase_q && from_q > lo) begin
							phase_d = 1'b1;
							pos_d   = lo;
							lim_d   = from_q;
							go_read = 1'b1;
						end else begin
							status_d = STS_NO_SPACE;
						end
					end
					MODE_RUN: begin
						if (run_ok) begin
							mode_d  = MODE_SET;
							pos_d   = run_start_q;
							lim_d   = run_start_q + count_q;
							go_read = 1'b1;
						end else if (fused.found) begin
							if (run_fail) begin
								status_d = STS_NO_SPACE;
							end else begin
								pos_d       = used_pg + 18'd1;
								run_start_d = used_pg + 18'd1;
								streak_d    = 18'd0;
								go_read     = 1'b1;
							end
						end else if (at_lim) begin
							status_d = STS_NO_SPACE;
						end else begin
							pos_d    = lim;
							streak_d = streak_new;
							go_read  = 1'b1;
						end
					end
					MODE_SET, MODE_CLR: begin
						mem_we = 1'b1;
						if (mode_q == MODE_SET) begin
							mem_wdata = rdata | wmask;
							changed_d = changed_q + 17'(pc_set);
						end else begin
							mem_wdata = rdata & ~wmask;
							changed_d = changed_q + 17'(pc_clr);
							dbl_d     = dbl_q | ffree.found;
						end
						if (at_lim) begin
							if (mode_q == MODE_SET) begin
								result_d = run_start_q[15:0];
							end
						end else begin
							pos_d   = lim;
							go_read = 1'b1;
						end
					end
					MODE_SINGLE: begin
						if (func_q == FN_QUERY) begin
							is_free_d = !bitv;
						end else if (bitv) begin
							status_d = STS_ALREADY_USED;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = rdata | (64'd1 << pos_q[5:0]);
							changed_d = 17'd1;
						end
					end
					default: begin
					end
				endcase
			end
			S_FIN: begin
				unique case (func_q)
					FN_ALLOC_ONE, FN_ALLOC_RUN, FN_RESERVE: begin
						free_d = sat_sub(free_q, changed_q);
						used_d = sat_add(used_q, changed_q);
					end
					FN_FREE_RUN: begin
						free_d = sat_add(free_q, changed_q);
						used_d = sat_sub(used_q, changed_q);
						if (status_q == STS_OK) begin
							if (dbl_q) begin
								status_d = STS_DOUBLE_FREE;
							end else if (over_q) begin
								status_d = STS_INVALID;
							end
						end
					end
					FN_BOOT_REL: begin
						free_d  = sat_add(free_q, changed_q);
						total_d = sat_add(total_q, changed_q);
					end
					default: begin
					end
				endcase
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == AW'(WORDS - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = go_read ? S_READ : S_FIN;
			S_READ:  state_d = S_EVAL;
			S_EVAL:  state_d = go_read ? S_READ : S_FIN;
			S_FIN:   state_d = S_DONE;
			S_DONE:  if (!out_stall) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != S_IDLE);
		out_valid     = (state_q == S_DONE);
		status        = status_q;
		result_page   = result_q;
		page_is_free  = is_free_q;
		pages_changed = changed_q;
		free_count    = free_q;
		used_count    = used_q;
		total_count   = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cursor_q <= 16'd0;
			free_q   <= 17'd0;
			used_q   <= 17'd0;
			total_q  <= 17'd0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			cursor_q <= cursor_d;
			free_q   <= free_d;
			used_q   <= used_d;
			total_q  <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q      <= mode_d;
		func_q      <= func_d;
		pos_q       <= pos_d;
		lim_q       <= lim_d;
		from_q      <= from_d;
		run_start_q <= run_start_d;
		streak_q    <= streak_d;
		count_q     <= count_d;
		phase_q     <= phase_d;
		dbl_q       <= dbl_d;
		over_q      <= over_d;
		status_q    <= status_d;
		result_q    <= result_d;
		is_free_q   <= is_free_d;
		changed_q   <= changed_d;
	end

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> $past(state_q) == S_READ)
		else $error("bitmap evaluated without a preceding read");

	a_no_write_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE || state_q == S_READ) |-> !mem_we)
		else $error("bitmap written outside an update step");

	a_idle_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after the word was taken");

	a_alloc_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q == STS_OK && (func_q == FN_ALLOC_ONE || func_q == FN_ALLOC_RUN)
		|-> {1'b0, result_q} >= cfg.lo)
		else $error("allocated page lies below the region");

endmodule

FILE: sv/bitmap_page_frame_allocator_top.sv
// Top level: region registers, effective region bound and the bitmap sequencer.
// Reserve and query read and evaluate one bitmap word; outcomes that touch only the counters read none.
// Single allocation reads and evaluates each 64-page bitmap word scanned, then updates the counters.
// Run allocation reads each bitmap word visited, restarts past each used page met, then marks word by word.
// Free run and boot release read and update each bitmap word of the range, one word at a time.
// After reset the bitmap is filled with ones, one word a cycle.
module bitmap_page_frame_allocator_top import bpfa_pkg::*; #(
	parameter int unsigned PAGES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] page_number,
	input  logic [16:0] run_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] result_page,
	output logic        page_is_free,
	output logic [16:0] pages_changed,
	output logic [16:0] free_count,
	output logic [16:0] used_count,
	output logic [16:0] total_count
);

	localparam int unsigned EFF = (PAGES < 65536) ? PAGES : 65536;
	localparam logic [16:0] EFF_P = 17'(EFF);

	logic [16:0] start_q, end_q, hi_cap;
	cfg_t cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 17'd0;
			end_q   <= 17'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REGION_START: start_q <= cfg_data;
				REG_REGION_END:   end_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		hi_cap = (end_q > EFF_P) ? EFF_P : end_q;
		cfg.lo = start_q;
		cfg.hi = (hi_cap < start_q) ? start_q : hi_cap;
	end

	bpfa_ctrl #(.PAGES(PAGES)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.page_number   (page_number),
		.run_length    (run_length),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.result_page   (result_page),
		.page_is_free  (page_is_free),
		.pages_changed (pages_changed),
		.free_count    (free_count),
		.used_count    (used_count),
		.total_count   (total_count)
	);

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the bitmap page frame allocator top level.
`timescale 1ns / 1ps

module testbench import bpfa_pkg::*;;

	localparam logic [2:0] FN_SPARE_6 = 3'd6;
	localparam logic [2:0] FN_SPARE_7 = 3'd7;
	localparam int NPAGES = 65536;
	localparam int CMAX = 131071;
	localparam int LIMIT = 1000000000;

	typedef struct {
		status_t     st;
		logic [15:0] page;
		logic        fr;
		cnt_t        changed;
		cnt_t        fcnt;
		cnt_t        ucnt;
		cnt_t        tcnt;
	} reply_t;

	typedef struct {
		logic [2:0]  f;
		logic [15:0] pg;
		logic [16:0] len;
		bit          typed;
		status_t     st;
		logic        fr;
	} row_t;

	typedef struct {
		int pg;
		int n;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_REGION_START;
	logic [16:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] func = '0;
	logic [15:0] page_number = '0;
	logic [16:0] run_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [15:0] result_page;
	logic page_is_free;
	logic [16:0] pages_changed, free_count, used_count, total_count;

	bitmap_page_frame_allocator_top u_top (.*);

	bit page_map [NPAGES];
	int cursor, free_held, used_held, total_held, reg_start, reg_end;
	grant_t grants[$];
	reply_t pending_replies[$];
	int errors = 0;
	int idle_pct = 0, stall_pct = 0;
	int hold_req = 0, hold_seen = 0, hold_left = 0;
	int cycles = 0;

	initial forever #4 clk = ~clk;

	function automatic int sat(input int v);
		return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
	endfunction

	function automatic int region_top();
		int h;
		h = (reg_end > NPAGES) ? NPAGES : reg_end;
		return (h < reg_start) ? reg_start : h;
	endfunction

	function automatic bit is_used(input int p);
		return (p >= NPAGES) ? 1'b1 : page_map[p];
	endfunction

	function automatic bit in_rgn(input int p);
		return p >= reg_start && p < region_top();
	endfunction

	function automatic bit take_one(output int pg);
		int lo, hi, span, from, p;
		lo = reg_start;
		hi = region_top();
		span = hi - lo;
		from = cursor;
		pg = 0;
		if (from < lo || from >= hi)
			from = lo;
		for (int n = 0; n < span; n++) begin
			p = from + n;
			if (p >= hi)
				p -= span;
			if (!is_used(p)) begin
				page_map[p] = 1'b1;
				free_held = sat(free_held - 1);
				used_held = sat(used_held + 1);
				cursor = (p + 1 < hi) ? p + 1 : lo;
				pg = p;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit take_run(input int cnt, output int pg);
		int hi, s;
		bit clear;
		hi = region_top();
		s = reg_start;
		pg = 0;
		while (s + cnt <= hi) begin
			clear = 1'b1;
			for (int i = 0; i < cnt; i++) begin
				if (is_used(s + i)) begin
					clear = 1'b0;
					s += i + 1;
					break;
				end
			end
			if (clear) begin
				for (int i = 0; i < cnt; i++)
					page_map[s + i] = 1'b1;
				free_held = sat(free_held - cnt);
				used_held = sat(used_held + cnt);
				pg = s;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic reply_t allocator_predict(input logic [2:0] f, input int p, input int l);
		reply_t r;
		int pg, ch, q;
		bit ok;
		r.st = STS_OK;
		r.fr = 1'b0;
		pg = 0;
		ch = 0;
		ok = 1'b0;
		case (f)
			FN_ALLOC_ONE, FN_ALLOC_RUN: begin
				if (f == FN_ALLOC_RUN && l == 0)
					r.st = STS_ZERO_COUNT;
				else begin
					ok = (f == FN_ALLOC_ONE || l == 1) ? take_one(pg) : take_run(l, pg);
					if (ok) begin
						ch = (f == FN_ALLOC_ONE) ? 1 : l;
						grants.push_back('{pg, ch});
					end else
						r.st = STS_NO_SPACE;
				end
			end
			FN_FREE_RUN: begin
				if (l == 0)
					r.st = STS_ZERO_COUNT;
				for (int i = 0; i < l; i++) begin
					q = p + i;
					if (!in_rgn(q)) begin
						if (r.st == STS_OK)
							r.st = STS_INVALID;
					end else if (!is_used(q)) begin
						if (r.st == STS_OK)
							r.st = STS_DOUBLE_FREE;
					end else begin
						page_map[q] = 1'b0;
						free_held = sat(free_held + 1);
						used_held = sat(used_held - 1);
						ch++;
					end
				end
			end
			FN_RESERVE: begin
				if (!in_rgn(p))
					r.st = STS_INVALID;
				else if (is_used(p))
					r.st = STS_ALREADY_USED;
				else begin
					page_map[p] = 1'b1;
					free_held = sat(free_held - 1);
					used_held = sat(used_held + 1);
					ch = 1;
				end
			end
			FN_QUERY: r.fr = in_rgn(p) && !is_used(p);
			FN_BOOT_REL: begin
				if (l == 0)
					r.st = STS_ZERO_COUNT;
				else begin
					for (int i = 0; i < l && p + i < NPAGES; i++) begin
						if (page_map[p + i]) begin
							page_map[p + i] = 1'b0;
							ch++;
						end
					end
					free_held = sat(free_held + ch);
					total_held = sat(total_held + ch);
				end
			end
			default: ;
		endcase
		r.page = (ok && r.st == STS_OK) ? 16'(pg) : 16'd0;
		r.changed = cnt_t'(ch);
		r.fcnt = cnt_t'(free_held);
		r.ucnt = cnt_t'(used_held);
		r.tcnt = cnt_t'(total_held);
		return r;
	endfunction

	task automatic send_word(input logic [2:0] f, input logic [15:0] p, input logic [16:0] l,
			input bit typed = 1'b0, input status_t tst = STS_OK, input logic tfr = 1'b0);
		reply_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		page_number <= p;
		run_length <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = allocator_predict(f, p, l);
		if (typed)
			r = '{tst, 16'd0, tfr, '0, '0, '0, '0};
		pending_replies.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_region(input int s, input int e);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_REGION_START;
		cfg_data <= 17'(s);
		@(posedge clk);
		cfg_index <= REG_REGION_END;
		cfg_data <= 17'(e);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_start = s;
		reg_end = e;
	endtask

	task automatic random_word(input int lo, input int span);
		logic [2:0] f;
		int p, l, k, sel;
		grant_t g;
		sel = $urandom_range(99);
		if (sel < 25) f = FN_ALLOC_ONE;
		else if (sel < 45) f = FN_ALLOC_RUN;
		else if (sel < 67) f = FN_FREE_RUN;
		else if (sel < 78) f = FN_RESERVE;
		else if (sel < 89) f = FN_QUERY;
		else if (sel < 97) f = FN_BOOT_REL;
		else f = sel[0] ? FN_SPARE_6 : FN_SPARE_7;
		if (span > 0 && $urandom_range(99) < 85)
			p = lo - 2 + $urandom_range(span + 3);
		else
			p = $urandom_range(65535);
		p = p & 16'hFFFF;
		k = $urandom_range(99);
		if (k < 60) l = $urandom_range(4, 1);
		else if (k < 85) l = $urandom_range(40, 5);
		else if (k < 93) l = 0;
		else if (k < 96) l = 65536;
		else if (k < 98) l = CMAX;
		else l = $urandom_range(CMAX);
		if (f == FN_ALLOC_RUN && l > 64 && l < 65536)
			l = $urandom_range(64, 2);
		if (f == FN_FREE_RUN && grants.size() != 0 && $urandom_range(1)) begin
			k = $urandom_range(grants.size() - 1);
			g = grants[k];
			grants.delete(k);
			p = g.pg;
			l = g.n;
		end
		send_word(f, 16'(p), 17'(l));
	endtask

	row_t rows [] = '{
		'{FN_ALLOC_ONE, 16'd0, 17'd0, 1'b1, STS_NO_SPACE, 1'b0},
		'{FN_ALLOC_RUN, 16'd0, 17'd0, 1'b1, STS_ZERO_COUNT, 1'b0},
		'{FN_ALLOC_RUN, 16'd0, 17'd2, 1'b1, STS_NO_SPACE, 1'b0},
		'{FN_FREE_RUN, 16'hFFFF, 17'd1, 1'b1, STS_INVALID, 1'b0},
		'{FN_RESERVE, 16'd0, 17'd0, 1'b1, STS_INVALID, 1'b0},
		'{FN_QUERY, 16'hFFFF, 17'd0, 1'b1, STS_OK, 1'b0},
		'{FN_BOOT_REL, 16'd0, 17'd0, 1'b1, STS_ZERO_COUNT, 1'b0},
		'{FN_FREE_RUN, 16'd0, 17'd0, 1'b1, STS_ZERO_COUNT, 1'b0},
		'{FN_SPARE_6, 16'd0, 17'd0, 1'b1, STS_OK, 1'b0},
		'{FN_SPARE_7, 16'hFFFF, 17'h1FFFF, 1'b1, STS_OK, 1'b0},
		'{FN_BOOT_REL, 16'd0, 17'd100, 1'b0, STS_OK, 1'b0},
		'{FN_ALLOC_ONE, 16'd0, 17'd0, 1'b0, STS_OK, 1'b0},
		'{FN_ALLOC_ONE, 16'd0, 17'd0, 1'b0, STS_OK, 1'b0},
		'{FN_ALLOC_RUN, 16'd0, 17'd1, 1'b0, STS_OK, 1'b0},
		'{FN_ALLOC_RUN, 16'd0, 17'd5, 1'b0, STS_OK, 1'b0},
		'{FN_FREE_RUN, 16'd16, 17'd3, 1'b0, STS_OK, 1'b0},
		'{FN_FREE_RUN, 16'd10, 17'd10, 1'b0, STS_OK, 1'b0},
		'{FN_FREE_RUN, 16'd16, 17'd1, 1'b0, STS_OK, 1'b0},
		'{FN_RESERVE, 16'd17, 17'd0, 1'b0, STS_OK, 1'b0},
		'{FN_RESERVE, 16'd17, 17'd0, 1'b0, STS_OK, 1'b0},
		'{FN_QUERY, 16'd20, 17'd0, 1'b0, STS_OK, 1'b0},
		'{FN_QUERY, 16'd16, 17'd0, 1'b0, STS_OK, 1'b0},
		'{FN_ALLOC_RUN, 16'd0, 17'h10000, 1'b0, STS_OK, 1'b0},
		'{FN_ALLOC_RUN, 16'd0, 17'd64, 1'b0, STS_OK, 1'b0},
		'{FN_BOOT_REL, 16'hFFFF, 17'h1FFFF, 1'b0, STS_OK, 1'b0},
		'{FN_FREE_RUN, 16'hFFFF, 17'h10000, 1'b0, STS_OK, 1'b0}
	};

	// Region bounds, word count and handshake mode of each random phase.
	int ph_start [8] = '{0, 100, 65280, 1000, 0, 7, 65536, 40000};
	int ph_end   [8] = '{65536, 356, CMAX, 1064, 300, 5, 65536, 40500};
	int ph_words [8] = '{80, 300, 250, 300, 300, 40, 30, 350};
	int mode_idle  [4] = '{0, 78, 0, 26};
	int mode_stall [4] = '{0, 0, 78, 26};

	initial begin
		int lo, span;
		for (int i = 0; i < NPAGES; i++)
			page_map[i] = 1'b1;
		cursor = 0;
		free_held = 0;
		used_held = 0;
		total_held = 0;
		reg_start = 0;
		reg_end = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < rows.size(); i++) begin
			if (i == 10)
				set_region(16, 80);
			send_word(rows[i].f, rows[i].pg, rows[i].len, rows[i].typed, rows[i].st, rows[i].fr);
		end
		for (int ph = 0; ph < 8; ph++) begin
			set_region(ph_start[ph], ph_end[ph]);
			idle_pct = mode_idle[ph % 4];
			stall_pct = mode_stall[ph % 4];
			grants.delete();
			lo = reg_start;
			span = region_top() - reg_start;
			if (ph == 7)
				hold_req++;
			send_word(FN_BOOT_REL, 16'(lo & 16'hFFFF), 17'(span));
			for (int n = 0; n < ph_words[ph]; n++)
				random_word(lo, span);
		end
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual status %0d", $time, status);
			end else begin
				e = pending_replies.pop_front();
				check_field("status", e.st, status);
				check_field("result_page", e.page, result_page);
				check_field("page_is_free", e.fr, page_is_free);
				check_field("pages_changed", e.changed, pages_changed);
				check_field("free_count", e.fcnt, free_count);
				check_field("used_count", e.ucnt, used_count);
				check_field("total_count", e.tcnt, total_count);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
